// File: src/ppa_pkg.sv
`default_nettype none

package ppa_pkg;

    // Component width of the pixel datapath (8 to 16 bits).
    localparam int COMPONENT_BITS = 16;

    // Fixed widths of the fields and registers.
    localparam int FIELD_W      = 16;
    localparam int OP_W         = 4;
    localparam int BRIGHT_W     = 25;
    localparam int GAIN_W       = 16;
    localparam int COLOR_OFF_W  = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 25;

    // Fixed point formats.
    localparam int BRI_FRAC     = 8;
    localparam int CON_FRAC     = 12;
    localparam int CENTER       = 128;

    // Internal arithmetic widths, all derived from the component width.
    localparam int BRI_W  = ((COMPONENT_BITS + BRI_FRAC + 1 > BRIGHT_W) ?
                             COMPONENT_BITS + BRI_FRAC + 1 : BRIGHT_W) + 1;
    localparam int DIFF_W = COMPONENT_BITS + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int CON_W  = PROD_W + 1;
    localparam int COL_W  = ((COMPONENT_BITS + 1 > COLOR_OFF_W) ?
                             COMPONENT_BITS + 1 : COLOR_OFF_W) + 1;

    // Pipeline depth of one lane.
    localparam int NUM_STAGES = 4;

    // Bit positions in op_enable.
    localparam int OP_BRIGHT   = 0;
    localparam int OP_CONTRAST = 1;
    localparam int OP_COLOR    = 2;
    localparam int OP_NEGATIVE = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OP_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_GREEN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BLUE  = 3'd6;

    // Reset values of the registers.
    localparam int MAX_VALUE_RESET = 255;
    localparam int GAIN_RESET      = 4096;

    typedef struct packed {
        logic [FIELD_W-1:0] in_red;
        logic [FIELD_W-1:0] in_green;
        logic [FIELD_W-1:0] in_blue;
    } pixel_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] out_red;
        logic [FIELD_W-1:0] out_green;
        logic [FIELD_W-1:0] out_blue;
    } pixel_out_t;

    // Settings shared by all lanes.
    typedef struct packed {
        logic [COMPONENT_BITS-1:0] max_value;
        logic [OP_W-1:0]           op_enable;
        logic signed [BRIGHT_W-1:0] brightness_offset;
        logic [GAIN_W-1:0]         contrast_gain;
    } ppa_cfg_t;

    // Per-stage load strobes for the lane data registers.
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } ppa_ctl_t;

endpackage

`default_nettype wire

// File: src/ppa_lane.sv
`default_nettype none

// One color channel: brightness, contrast multiply, contrast finish,
// then color offset and negative, one register stage each.
module ppa_lane (
    input  wire logic                                 aclk,
    input  wire ppa_pkg::ppa_cfg_t                    cfg,
    input  wire logic signed [ppa_pkg::COLOR_OFF_W-1:0] color_offset,
    input  wire ppa_pkg::ppa_ctl_t                    ctl,
    input  wire logic [ppa_pkg::COMPONENT_BITS-1:0]   in_comp,
    output logic [ppa_pkg::COMPONENT_BITS-1:0]        out_comp
);

    localparam int C      = ppa_pkg::COMPONENT_BITS;
    localparam int BRI_W  = ppa_pkg::BRI_W;
    localparam int BRI_Q  = BRI_W - 1 - ppa_pkg::BRI_FRAC;
    localparam int PROD_W = ppa_pkg::PROD_W;
    localparam int CON_W  = ppa_pkg::CON_W;
    localparam int CON_Q  = CON_W - 1 - ppa_pkg::CON_FRAC;
    localparam int COL_W  = ppa_pkg::COL_W;

    logic [C-1:0]             v1_reg, v1_next;
    logic [C-1:0]             v2_reg, v2_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [C-1:0]             v3_reg, v3_next;
    logic [C-1:0]             v4_reg, v4_next;

    logic signed [BRI_W-1:0]  bri_sum;
    logic [BRI_Q-1:0]         bri_q;
    logic signed [ppa_pkg::DIFF_W-1:0] diff;
    logic signed [CON_W-1:0]  con_sum;
    logic [CON_Q-1:0]         con_q;
    logic signed [COL_W-1:0]  col_sum;
    logic [COL_W-2:0]         col_q;
    logic [C-1:0]             col_v;
    logic [C:0]               neg;

    // Brightness: add the Q8 offset; a negative sum clamps to zero.
    always_comb begin
        bri_sum = $signed(BRI_W'({in_comp, {ppa_pkg::BRI_FRAC{1'b0}}}))
                + $signed({{(BRI_W-ppa_pkg::BRIGHT_W){cfg.brightness_offset[ppa_pkg::BRIGHT_W-1]}},
                           cfg.brightness_offset});
        bri_q = bri_sum[BRI_W-2:ppa_pkg::BRI_FRAC];
        v1_next = in_comp;
        if (cfg.op_enable[ppa_pkg::OP_BRIGHT]) begin
            if (bri_sum[BRI_W-1]) begin
                v1_next = '0;
            end else if (bri_q > BRI_Q'(cfg.max_value)) begin
                v1_next = cfg.max_value;
            end else begin
                v1_next = bri_q[C-1:0];
            end
        end
    end

    // Contrast, first half: gain times distance from the center.
    always_comb begin
        diff = $signed({1'b0, v1_reg}) - $signed(ppa_pkg::DIFF_W'(ppa_pkg::CENTER));
        prod_next = diff * $signed({1'b0, cfg.contrast_gain});
        v2_next = v1_reg;
    end

    // Contrast, second half: add the center back and clamp.
    always_comb begin
        con_sum = $signed({prod_reg[PROD_W-1], prod_reg})
                + $signed(CON_W'(ppa_pkg::CENTER) <<< ppa_pkg::CON_FRAC);
        con_q = con_sum[CON_W-2:ppa_pkg::CON_FRAC];
        v3_next = v2_reg;
        if (cfg.op_enable[ppa_pkg::OP_CONTRAST]) begin
            if (con_sum[CON_W-1]) begin
                v3_next = '0;
            end else if (con_q > CON_Q'(cfg.max_value)) begin
                v3_next = cfg.max_value;
            end else begin
                v3_next = con_q[C-1:0];
            end
        end
    end

    // Color offset with clamp, then negative with a floor at zero.
    always_comb begin
        col_sum = $signed(COL_W'(v3_reg))
                + $signed({{(COL_W-ppa_pkg::COLOR_OFF_W){color_offset[ppa_pkg::COLOR_OFF_W-1]}},
                           color_offset});
        col_q = col_sum[COL_W-2:0];
        col_v = v3_reg;
        if (cfg.op_enable[ppa_pkg::OP_COLOR]) begin
            if (col_sum[COL_W-1]) begin
                col_v = '0;
            end else if (col_q > (COL_W-1)'(cfg.max_value)) begin
                col_v = cfg.max_value;
            end else begin
                col_v = col_q[C-1:0];
            end
        end
        neg = {1'b0, cfg.max_value} - {1'b0, col_v};
        v4_next = col_v;
        if (cfg.op_enable[ppa_pkg::OP_NEGATIVE]) begin
            v4_next = neg[C] ? '0 : neg[C-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load[0]) begin
            v1_reg <= v1_next;
        end
        if (ctl.load[1]) begin
            v2_reg   <= v2_next;
            prod_reg <= prod_next;
        end
        if (ctl.load[2]) begin
            v3_reg <= v3_next;
        end
        if (ctl.load[3]) begin
            v4_reg <= v4_next;
        end
    end

    assign out_comp = v4_reg;

endmodule

`default_nettype wire

// File: src/ppa_merge.sv
`default_nettype none

// Gathers the three lane results into one output pixel and holds it in
// the output register until the receiver takes it.
module ppa_merge (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               lane_valid,
    input  wire logic [ppa_pkg::COMPONENT_BITS-1:0] red,
    input  wire logic [ppa_pkg::COMPONENT_BITS-1:0] green,
    input  wire logic [ppa_pkg::COMPONENT_BITS-1:0] blue,
    output logic                                    out_free,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output ppa_pkg::pixel_out_t                     m_data
);

    logic                 m_valid_reg, m_valid_next;
    ppa_pkg::pixel_out_t  data_reg, data_next;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = out_free ? lane_valid : m_valid_reg;
        data_next.out_red   = ppa_pkg::FIELD_W'(red);
        data_next.out_green = ppa_pkg::FIELD_W'(green);
        data_next.out_blue  = ppa_pkg::FIELD_W'(blue);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && lane_valid) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

// File: src/pixel_point_adjust.sv
// Per-pixel RGB point adjust: brightness, contrast, color offset, negative.
//
// Pixels arrive on the s_ channel (s_valid, s_ready, s_data) and results
// leave on the m_ channel (m_valid, m_ready, m_data). A request moves when
// valid and ready are both high at a rising edge of aclk.
// Settings are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write them only while no pixel is in
// flight.
// Each color channel runs in its own four-stage lane; the output register
// in the merge stage joins the three lanes into one result. A result shows
// on m_valid once it has passed the four lane stages and the output
// register; one pixel per cycle is sustained while m_ready stays high. The
// depth comes from the contrast multiplier, which has a register on each side.
// When the receiver stalls, the pipeline keeps filling its empty stages,
// so s_ready drops only once all four stages and the output are full.
// A synchronous low aresetn empties the pipeline and loads the register
// defaults: max_value 255, all operations off, contrast gain 1.0.
`default_nettype none

module pixel_point_adjust (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Pixel input.
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire ppa_pkg::pixel_in_t                  s_data,
    // Pixel output.
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output ppa_pkg::pixel_out_t                      m_data,
    // Configuration writes.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ppa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ppa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int C  = ppa_pkg::COMPONENT_BITS;
    localparam int NS = ppa_pkg::NUM_STAGES;
    localparam int OW = ppa_pkg::COLOR_OFF_W;

    // Configuration registers.
    ppa_pkg::ppa_cfg_t       cfg_reg, cfg_next;
    logic signed [OW-1:0]    off_red_reg, off_red_next;
    logic signed [OW-1:0]    off_green_reg, off_green_next;
    logic signed [OW-1:0]    off_blue_reg, off_blue_next;
    logic [ppa_pkg::FIELD_W-1:0] max_wr;

    // Pipeline control.
    logic [NS-1:0]           stage_valid_reg, stage_valid_next;
    logic [NS-1:0]           free;
    logic                    out_free;
    ppa_pkg::ppa_ctl_t       ctl;

    logic [C-1:0]            red_res, green_res, blue_res;

    assign cfg_ready = 1'b1;

    // A max_value wider than the component width saturates to full scale.
    always_comb begin
        cfg_next       = cfg_reg;
        off_red_next   = off_red_reg;
        off_green_next = off_green_reg;
        off_blue_next  = off_blue_reg;
        max_wr         = cfg_data[ppa_pkg::FIELD_W-1:0];
        if (cfg_valid) begin
            unique case (cfg_index)
                ppa_pkg::REG_MAX_VALUE: begin
                    if (max_wr > ppa_pkg::FIELD_W'({C{1'b1}})) begin
                        cfg_next.max_value = {C{1'b1}};
                    end else begin
                        cfg_next.max_value = max_wr[C-1:0];
                    end
                end
                ppa_pkg::REG_OP_ENABLE: begin
                    cfg_next.op_enable = cfg_data[ppa_pkg::OP_W-1:0];
                end
                ppa_pkg::REG_BRIGHTNESS: begin
                    cfg_next.brightness_offset = $signed(cfg_data[ppa_pkg::BRIGHT_W-1:0]);
                end
                ppa_pkg::REG_CONTRAST: begin
                    cfg_next.contrast_gain = cfg_data[ppa_pkg::GAIN_W-1:0];
                end
                ppa_pkg::REG_OFFSET_RED: begin
                    off_red_next = $signed(cfg_data[OW-1:0]);
                end
                ppa_pkg::REG_OFFSET_GREEN: begin
                    off_green_next = $signed(cfg_data[OW-1:0]);
                end
                ppa_pkg::REG_OFFSET_BLUE: begin
                    off_blue_next = $signed(cfg_data[OW-1:0]);
                end
                default: begin
                    // Writes past the last register are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_value         <= C'(ppa_pkg::MAX_VALUE_RESET);
            cfg_reg.op_enable         <= '0;
            cfg_reg.brightness_offset <= '0;
            cfg_reg.contrast_gain     <= ppa_pkg::GAIN_W'(ppa_pkg::GAIN_RESET);
            off_red_reg               <= '0;
            off_green_reg             <= '0;
            off_blue_reg              <= '0;
        end else begin
            cfg_reg       <= cfg_next;
            off_red_reg   <= off_red_next;
            off_green_reg <= off_green_next;
            off_blue_reg  <= off_blue_next;
        end
    end

    // A stage may load when it is empty or when the stage after it moves
    // on in the same cycle. Bubbles therefore collapse under a stall.
    always_comb begin
        free[NS-1] = !stage_valid_reg[NS-1] || out_free;
        for (int k = NS - 2; k >= 0; k--) begin
            free[k] = !stage_valid_reg[k] || free[k+1];
        end
        stage_valid_next[0] = free[0] ? s_valid : stage_valid_reg[0];
        ctl.load[0]         = free[0] && s_valid;
        for (int k = 1; k < NS; k++) begin
            stage_valid_next[k] = free[k] ? stage_valid_reg[k-1] : stage_valid_reg[k];
            ctl.load[k]         = free[k] && stage_valid_reg[k-1];
        end
    end

    assign s_ready = free[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    ppa_lane u_lane_red (
        .aclk         (aclk),
        .cfg          (cfg_reg),
        .color_offset (off_red_reg),
        .ctl          (ctl),
        .in_comp      (s_data.in_red[C-1:0]),
        .out_comp     (red_res)
    );

    ppa_lane u_lane_green (
        .aclk         (aclk),
        .cfg          (cfg_reg),
        .color_offset (off_green_reg),
        .ctl          (ctl),
        .in_comp      (s_data.in_green[C-1:0]),
        .out_comp     (green_res)
    );

    ppa_lane u_lane_blue (
        .aclk         (aclk),
        .cfg          (cfg_reg),
        .color_offset (off_blue_reg),
        .ctl          (ctl),
        .in_comp      (s_data.in_blue[C-1:0]),
        .out_comp     (blue_res)
    );

    ppa_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .lane_valid (stage_valid_reg[NS-1]),
        .red        (red_res),
        .green      (green_res),
        .blue       (blue_res),
        .out_free   (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // The input stalls only when every stage and the output are occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (stage_valid_reg == {NS{1'b1}}) && m_valid && !m_ready)
        else $error("input stalled while the pipeline had room");

    // A taken request always lands in the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> stage_valid_reg[0])
        else $error("accepted pixel did not enter the first stage");

    // A finished lane result moves to the output whenever it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg[NS-1] && out_free) |=> m_valid)
        else $error("lane result lost on the way to the output");

    // The last stage keeps a pixel that it cannot move on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg[NS-1] && !out_free) |=> stage_valid_reg[NS-1])
        else $error("last stage dropped a stalled pixel");

endmodule

`default_nettype wire

// File: bench/tb_pixel_point_adjust.sv
`timescale 1ns / 100ps

// Testbench for the pixel point adjust block.
module tb_pixel_point_adjust;

    // Package constants and types used here.
    localparam int NUM_STAGES      = ppa_pkg::NUM_STAGES;
    localparam int CFG_IDX_W       = ppa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W      = ppa_pkg::CFG_DATA_W;
    localparam int OP_W            = ppa_pkg::OP_W;
    localparam int OP_BRIGHT       = ppa_pkg::OP_BRIGHT;
    localparam int OP_CONTRAST     = ppa_pkg::OP_CONTRAST;
    localparam int OP_COLOR        = ppa_pkg::OP_COLOR;
    localparam int OP_NEGATIVE     = ppa_pkg::OP_NEGATIVE;
    localparam int FIELD_W         = ppa_pkg::FIELD_W;
    localparam int COMPONENT_BITS  = ppa_pkg::COMPONENT_BITS;
    localparam int MAX_VALUE_RESET = ppa_pkg::MAX_VALUE_RESET;
    localparam int BRIGHT_W        = ppa_pkg::BRIGHT_W;
    localparam int GAIN_W          = ppa_pkg::GAIN_W;
    localparam int GAIN_RESET      = ppa_pkg::GAIN_RESET;
    localparam int COLOR_OFF_W     = ppa_pkg::COLOR_OFF_W;
    localparam int BRI_FRAC        = ppa_pkg::BRI_FRAC;
    localparam int CON_FRAC        = ppa_pkg::CON_FRAC;
    localparam int CENTER          = ppa_pkg::CENTER;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE    = ppa_pkg::REG_MAX_VALUE;
    localparam logic [CFG_IDX_W-1:0] REG_OP_ENABLE    = ppa_pkg::REG_OP_ENABLE;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = ppa_pkg::REG_BRIGHTNESS;
    localparam logic [CFG_IDX_W-1:0] REG_CONTRAST     = ppa_pkg::REG_CONTRAST;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_RED   = ppa_pkg::REG_OFFSET_RED;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_GREEN = ppa_pkg::REG_OFFSET_GREEN;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BLUE  = ppa_pkg::REG_OFFSET_BLUE;
    typedef ppa_pkg::pixel_in_t  pixel_in_t;
    typedef ppa_pkg::pixel_out_t pixel_out_t;

    // Number of lane stages a result passes before the output register.
    localparam int LATENCY        = NUM_STAGES;
    // Cycles in a row without any request before the run is declared hung.
    // The slowest correct stretch is one sender gap, one receiver stall and
    // the pipeline depth, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 400;
    localparam int MAX_WAIT       = 11;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_PIXELS   = 50;
    localparam int REPORT_CAP     = 10;

    // Index that maps to no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Operation enable codes built from the bit positions of the package.
    localparam logic [OP_W-1:0] EN_NONE     = '0;
    localparam logic [OP_W-1:0] EN_BRIGHT   = OP_W'(1 << OP_BRIGHT);
    localparam logic [OP_W-1:0] EN_CONTRAST = OP_W'(1 << OP_CONTRAST);
    localparam logic [OP_W-1:0] EN_COLOR    = OP_W'(1 << OP_COLOR);
    localparam logic [OP_W-1:0] EN_NEGATIVE = OP_W'(1 << OP_NEGATIVE);
    localparam logic [OP_W-1:0] EN_ALL      = EN_BRIGHT | EN_CONTRAST | EN_COLOR | EN_NEGATIVE;

    // Largest component value at the configured component width.
    localparam logic [FIELD_W-1:0] COMP_MASK = FIELD_W'((1 << COMPONENT_BITS) - 1);

    // Extreme register values from the legal ranges.
    localparam int BRIGHT_LIMIT = 16776960;
    localparam int OFFSET_LIMIT = 65535;

    // Clock, reset and every block input start at a known value.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pixel_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    pixel_out_t            m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Our own copy of the settings, updated when a register write is taken.
    logic [FIELD_W-1:0]         max_value_q = FIELD_W'(MAX_VALUE_RESET);
    logic [OP_W-1:0]            op_enable_q = EN_NONE;
    logic signed [BRIGHT_W-1:0] bright_q    = '0;
    logic [GAIN_W-1:0]          gain_q      = GAIN_W'(GAIN_RESET);
    logic signed [COLOR_OFF_W-1:0] offset_red_q   = '0;
    logic signed [COLOR_OFF_W-1:0] offset_green_q = '0;
    logic signed [COLOR_OFF_W-1:0] offset_blue_q  = '0;

    // Pixels waiting to be driven, and the adjusted pixels we expect back.
    pixel_in_t  pixel_queue[$];
    pixel_out_t expected_pixels[$];

    // Idle budgets of the current phase; zero gives back-to-back traffic.
    int unsigned s_gap_max   = 0;
    int unsigned m_stall_max = 0;
    int unsigned gap_left    = 0;
    int unsigned stall_left  = 0;

    int pixels_queued   = 0;
    int pixels_accepted = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int phase_count     = 0;
    int error_count     = 0;
    int idle_cycles     = 0;

    pixel_point_adjust i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Only the first few errors are printed; the rest are only counted.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= REPORT_CAP) begin
            $display("%s", msg);
        end
    endtask

    // Wait cycles before the next request on one side. At least a quarter of
    // the draws are zero so that back-to-back requests still occur.
    function automatic int unsigned draw_wait(input int unsigned cap);
        if (cap == 0 || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, cap);
    endfunction

    function automatic longint clamp_to_max(input longint v, input longint mx);
        if (v < 0) begin
            return 0;
        end
        if (v > mx) begin
            return mx;
        end
        return v;
    endfunction

    // Expected value of one component after all enabled operations, in
    // the fixed order brightness, contrast, color offset, negative.
    // A negative fixed point sum always ends at zero after the clamp, so an
    // arithmetic shift gives the same result as truncation toward zero.
    function automatic logic [FIELD_W-1:0] adjust_component(
        input logic [FIELD_W-1:0]        comp,
        input logic signed [COLOR_OFF_W-1:0] color_off
    );
        longint mx;
        longint v;
        longint s;
        mx = longint'(max_value_q);
        v  = longint'(comp & COMP_MASK);
        if (op_enable_q[OP_BRIGHT]) begin
            s = v * 256 + longint'(bright_q);
            v = clamp_to_max(s >>> BRI_FRAC, mx);
        end
        if (op_enable_q[OP_CONTRAST]) begin
            s = longint'(gain_q) * (v - CENTER) + (longint'(CENTER) << CON_FRAC);
            v = clamp_to_max(s >>> CON_FRAC, mx);
        end
        if (op_enable_q[OP_COLOR]) begin
            v = clamp_to_max(v + longint'(color_off), mx);
        end
        if (op_enable_q[OP_NEGATIVE]) begin
            v = mx - v;
            if (v < 0) begin
                v = 0;
            end
        end
        return v[FIELD_W-1:0];
    endfunction

    // Component draws for the random part. Most stay within max_value, a
    // few hit the ends, and noise pixels use the full field so that every
    // input bit toggles even when max_value is small.
    function automatic logic [FIELD_W-1:0] draw_component(
        input logic [FIELD_W-1:0] mv,
        input bit                 noise
    );
        if (noise) begin
            return FIELD_W'($urandom);
        end
        case ($urandom_range(0, 9))
            0: return '0;
            1: return mv;
            default: return FIELD_W'($urandom_range(0, int'(mv)));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_offset(input logic [FIELD_W-1:0] mv);
        case ($urandom_range(0, 4))
            0: return CFG_DATA_W'(OFFSET_LIMIT);
            1: return CFG_DATA_W'(-OFFSET_LIMIT);
            2: return CFG_DATA_W'($urandom_range(0, 2 * OFFSET_LIMIT) - OFFSET_LIMIT);
            default: return CFG_DATA_W'($urandom_range(0, 2 * int'(mv)) - int'(mv));
        endcase
    endfunction

    // One register write request. It is called at a rising edge, keeps
    // cfg_valid high across back-to-back writes, and updates our copy of
    // the settings at the edge where the write is taken. The caller lowers
    // cfg_valid after the last write of a burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_writes++;
        case (idx)
            REG_MAX_VALUE: begin
                max_value_q = (data[FIELD_W-1:0] > COMP_MASK) ? COMP_MASK : data[FIELD_W-1:0];
            end
            REG_OP_ENABLE:    op_enable_q    = data[OP_W-1:0];
            REG_BRIGHTNESS:   bright_q       = data[BRIGHT_W-1:0];
            REG_CONTRAST:     gain_q         = data[GAIN_W-1:0];
            REG_OFFSET_RED:   offset_red_q   = data[COLOR_OFF_W-1:0];
            REG_OFFSET_GREEN: offset_green_q = data[COLOR_OFF_W-1:0];
            REG_OFFSET_BLUE:  offset_blue_q  = data[COLOR_OFF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(
        input logic [FIELD_W-1:0] r,
        input logic [FIELD_W-1:0] g,
        input logic [FIELD_W-1:0] b
    );
        pixel_in_t px;
        px.in_red   = r;
        px.in_green = g;
        px.in_blue  = b;
        pixel_queue.push_back(px);
        pixels_queued++;
    endtask

    // Every pixel gives exactly one result, so the block is idle once as
    // many results have been checked as pixels were queued. This closes a
    // phase before the next settings are written.
    task automatic drain();
        while (results_checked < pixels_queued) begin
            @(posedge aclk);
        end
        phase_count++;
    endtask

    // Pixel driver. At each edge it first records a request the block took,
    // predicting its result from the settings in force, and then loads the
    // next pixel once the slot is free and the drawn gap has run out. The
    // payload never changes while a request is waiting for s_ready.
    always @(posedge aclk) begin : pixel_driver
        pixel_out_t predicted;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted.out_red   = adjust_component(s_data.in_red, offset_red_q);
                predicted.out_green = adjust_component(s_data.in_green, offset_green_q);
                predicted.out_blue  = adjust_component(s_data.in_blue, offset_blue_q);
                expected_pixels.push_back(predicted);
                pixels_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    s_data   <= pixel_queue.pop_front();
                    s_valid  <= 1'b1;
                    gap_left <= draw_wait(s_gap_max);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each result taken is compared field by field with the
    // oldest expectation. After every result m_ready may drop for a drawn
    // number of cycles, so stalls land on every stage of the pipeline.
    always @(posedge aclk) begin : result_monitor
        pixel_out_t  want;
        int unsigned stall;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_error($sformatf("unexpected result %h %h %h with nothing pending",
                                           m_data.out_red, m_data.out_green, m_data.out_blue));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_data.out_red !== want.out_red || m_data.out_green !== want.out_green ||
                        m_data.out_blue !== want.out_blue) begin
                        report_error($sformatf(
                            "result %0d mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                            results_checked, want.out_red, want.out_green, want.out_blue,
                            m_data.out_red, m_data.out_green, m_data.out_blue));
                    end
                    results_checked++;
                end
                stall = draw_wait(m_stall_max);
                m_ready    <= (stall == 0);
                stall_left <= stall;
            end else if (!m_ready) begin
                if (stall_left <= 1) begin
                    m_ready <= 1'b1;
                end
                if (stall_left > 0) begin
                    stall_left <= stall_left - 1;
                end
            end
        end
    end

    // Watchdog: any request on any channel restarts the count.
    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
                         idle_cycles, pixels_queued - results_checked);
                $display("tb_pixel_point_adjust: FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [FIELD_W-1:0]  mv;
        logic [OP_W-1:0]     ops;
        logic [CFG_DATA_W-1:0] bright;
        logic [GAIN_W-1:0]   gain;
        bit                  noise;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: no operation is on, so every pixel comes back as
        // it went in, including components above the default max_value.
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0100, 16'h8000, 16'h00FF);
        drain();

        // Negative alone. A component above max_value turns negative and
        // must be clamped to zero.
        s_gap_max   = MAX_WAIT;
        m_stall_max = MAX_WAIT;
        write_reg(REG_OP_ENABLE, CFG_DATA_W'(EN_NEGATIVE));
        cfg_valid <= 1'b0;
        send_pixel(16'd0, 16'd255, 16'd300);
        send_pixel(16'hFFFF, 16'd128, 16'd1);
        drain();

        // A zero max_value makes every clamp give zero.
        write_reg(REG_MAX_VALUE, '0);
        write_reg(REG_OP_ENABLE, CFG_DATA_W'(EN_ALL));
        cfg_valid <= 1'b0;
        send_pixel(16'd0, 16'd1, 16'hFFFF);
        drain();

        // Every register but the blue offset at its upper or lower extreme, with all operations on.
        s_gap_max   = 0;
        m_stall_max = 0;
        write_reg(REG_MAX_VALUE, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_BRIGHTNESS, CFG_DATA_W'(BRIGHT_LIMIT));
        write_reg(REG_CONTRAST, CFG_DATA_W'(16'hFFFF));
        write_reg(REG_OFFSET_RED, CFG_DATA_W'(OFFSET_LIMIT));
        write_reg(REG_OFFSET_GREEN, CFG_DATA_W'(-OFFSET_LIMIT));
        write_reg(REG_OFFSET_BLUE, '0);
        cfg_valid <= 1'b0;
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'd128, 16'd127, 16'd129);
        drain();

        // Most negative brightness on its own.
        write_reg(REG_BRIGHTNESS, CFG_DATA_W'(-BRIGHT_LIMIT));
        write_reg(REG_OP_ENABLE, CFG_DATA_W'(EN_BRIGHT));
        cfg_valid <= 1'b0;
        send_pixel(16'hFFFF, 16'h0000, 16'h8000);
        drain();

        // Zero gain pulls everything to the contrast center, which here
        // lies above max_value: the center stays 128 whatever max_value is.
        write_reg(REG_MAX_VALUE, CFG_DATA_W'(100));
        write_reg(REG_CONTRAST, '0);
        write_reg(REG_OP_ENABLE, CFG_DATA_W'(EN_CONTRAST));
        cfg_valid <= 1'b0;
        send_pixel(16'd0, 16'd100, 16'hFFFF);
        drain();

        // Half a step of brightness, up and then down: the fraction is
        // truncated toward zero in both directions.
        write_reg(REG_MAX_VALUE, CFG_DATA_W'(MAX_VALUE_RESET));
        write_reg(REG_CONTRAST, CFG_DATA_W'(GAIN_RESET));
        write_reg(REG_BRIGHTNESS, CFG_DATA_W'(128));
        write_reg(REG_OP_ENABLE, CFG_DATA_W'(EN_BRIGHT | EN_CONTRAST));
        cfg_valid <= 1'b0;
        send_pixel(16'd0, 16'd127, 16'd255);
        drain();
        write_reg(REG_BRIGHTNESS, CFG_DATA_W'(-128));
        write_reg(REG_OP_ENABLE, CFG_DATA_W'(EN_BRIGHT));
        cfg_valid <= 1'b0;
        send_pixel(16'd0, 16'd1, 16'd255);
        drain();

        // Gain 1.5 below the center yields negative fractions.
        write_reg(REG_CONTRAST, CFG_DATA_W'(16'h1800));
        write_reg(REG_OP_ENABLE, CFG_DATA_W'(EN_CONTRAST));
        cfg_valid <= 1'b0;
        send_pixel(16'd0, 16'd127, 16'd200);
        drain();

        // Color offsets alone, clamped at both ends.
        write_reg(REG_MAX_VALUE, CFG_DATA_W'(1000));
        write_reg(REG_OFFSET_RED, CFG_DATA_W'(1));
        write_reg(REG_OFFSET_GREEN, CFG_DATA_W'(-1));
        write_reg(REG_OFFSET_BLUE, CFG_DATA_W'(OFFSET_LIMIT));
        write_reg(REG_OP_ENABLE, CFG_DATA_W'(EN_COLOR));
        cfg_valid <= 1'b0;
        send_pixel(16'd0, 16'd0, 16'd999);
        drain();

        // A write to an index past the last register must be ignored.
        write_reg(REG_UNUSED, '1);
        cfg_valid <= 1'b0;
        send_pixel(16'd500, 16'd1, 16'd0);
        drain();

        // Random part: each phase writes every register with a fresh
        // setting, biased toward the extremes, then streams pixels with
        // random content under its own idling budgets.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0: mv = 16'd1;
                1: mv = 16'd255;
                2: mv = 16'hFFFF;
                3: mv = 16'd1023;
                default: mv = FIELD_W'($urandom_range(1, 65535));
            endcase
            case ($urandom_range(0, 5))
                0: bright = CFG_DATA_W'(BRIGHT_LIMIT);
                1: bright = CFG_DATA_W'(-BRIGHT_LIMIT);
                2: bright = '0;
                3: bright = CFG_DATA_W'($urandom_range(0, 2 * BRIGHT_LIMIT) - BRIGHT_LIMIT);
                default: bright = CFG_DATA_W'($urandom_range(0, 2 * 256 * int'(mv)) -
                                              256 * int'(mv));
            endcase
            case ($urandom_range(0, 4))
                0: gain = '0;
                1: gain = 16'hFFFF;
                2: gain = GAIN_W'(GAIN_RESET);
                3: gain = GAIN_W'($urandom);
                default: gain = GAIN_W'($urandom_range(2048, 8192));
            endcase
            ops = ($urandom_range(0, 3) == 0) ? EN_ALL : OP_W'($urandom_range(0, 15));
            // Some phases run with no idling at all on one or both sides.
            s_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;
            m_stall_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_WAIT;

            write_reg(REG_MAX_VALUE, CFG_DATA_W'(mv));
            write_reg(REG_OP_ENABLE, CFG_DATA_W'(ops));
            write_reg(REG_BRIGHTNESS, bright);
            write_reg(REG_CONTRAST, CFG_DATA_W'(gain));
            write_reg(REG_OFFSET_RED, draw_offset(mv));
            write_reg(REG_OFFSET_GREEN, draw_offset(mv));
            write_reg(REG_OFFSET_BLUE, draw_offset(mv));
            cfg_valid <= 1'b0;

            for (int n = 0; n < PHASE_PIXELS; n++) begin
                noise = ($urandom_range(0, 9) == 0);
                send_pixel(draw_component(mv, noise), draw_component(mv, noise),
                           draw_component(mv, noise));
            end
            drain();
        end

        // Let the pipeline run empty to catch any stray extra result.
        repeat (LATENCY + 4) @(posedge aclk);
        if (expected_pixels.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_pixels.size()));
        end

        $display("Run covered %0d pixels over %0d settings phases with %0d register writes.",
                 pixels_accepted, phase_count, cfg_writes);
        $display("Checked %0d results, found %0d errors.", results_checked, error_count);
        if (error_count == 0) begin
            $display("tb_pixel_point_adjust: PASS");
        end else begin
            $display("tb_pixel_point_adjust: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/ppa_pkg.sv
src/ppa_lane.sv
src/ppa_merge.sv
src/pixel_point_adjust.sv
bench/tb_pixel_point_adjust.sv
